[src/pfc_pkg.sv]
// Shared constants, types and mode codes for the pixel format converter.
package pfc_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int VGA_WIDTH     = 640;
    localparam int VGA_HEIGHT    = 480;
    localparam int VGA_ROW_BYTES = (VGA_WIDTH + 7) / 8;

    localparam int COL_W  = $clog2((MAX_WIDTH > VGA_WIDTH) ? MAX_WIDTH : VGA_WIDTH);
    localparam int ROW_W  = $clog2((MAX_HEIGHT > VGA_HEIGHT) ? MAX_HEIGHT : VGA_HEIGHT);
    localparam int WDIM_W = COL_W + 1;
    localparam int HDIM_W = ROW_W + 1;

    localparam int ADDR_W     = 26;
    localparam int WORD_W     = 32;
    localparam int INDEX_W    = 8;
    localparam int COUNT_W    = 3;
    localparam int MASK_W     = 4;
    localparam int MODE_W     = 3;
    localparam int DIM_REG_W  = 13;
    localparam int STRIDE_W   = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int PLANES     = 4;
    localparam int PLANE_W    = $clog2(PLANES);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 2'd3;

    localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
    localparam logic [STRIDE_W-1:0]  ROW_STRIDE_RESET   = 15'd2560;

    typedef enum logic [MODE_W-1:0] {
        MODE_VGA    = 3'd0,
        MODE_BYTE   = 3'd1,
        MODE_RGB15  = 3'd2,
        MODE_RGB16  = 3'd3,
        MODE_RGB24  = 3'd4,
        MODE_BGR24  = 3'd5,
        MODE_RGBX32 = 3'd6,
        MODE_BGRX32 = 3'd7
    } color_mode_t;

    // One queued write job: a single pixel write, or a VGA group of four plane bytes.
    typedef struct packed {
        logic               planar;
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] byte_count;
        logic [ADDR_W-1:0]  addr;
        logic               frame_last;
    } pfc_job_t;

endpackage

[src/pfc_front.sv]
// Front end: raster position tracking, VGA plane gathering and pixel packing into jobs.
module pfc_front
    import pfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic [INDEX_W-1:0]    pixel_index,
    output logic                  job_valid,
    output pfc_job_t              job
);

    color_mode_t                 color_mode_reg;
    logic [DIM_REG_W-1:0]        frame_width_reg;
    logic [DIM_REG_W-1:0]        frame_height_reg;
    logic [STRIDE_W-1:0]         row_stride_reg;

    logic [COL_W-1:0]            col_reg, col_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [ADDR_W-1:0]           base_reg, base_next;
    logic [PLANES-1:0][7:0]      gather_reg, gather_next;
    logic [2:0]                  fill_reg, fill_next;

    logic [WDIM_W-1:0]           width;
    logic [HDIM_W-1:0]           height;
    logic [STRIDE_W-1:0]         step;
    logic                        end_col;
    logic                        end_row;
    logic [PLANES-1:0][7:0]      gather_set;
    logic [7:0]                  pos_bit;
    logic                        vga_emit;
    logic [7:0]                  grey;
    logic [4:0]                  g5;
    logic [5:0]                  g6;
    logic [ADDR_W-1:0]           col_ext;
    logic [ADDR_W-1:0]           col_offset;
    logic [WORD_W-1:0]           word;
    logic [COUNT_W-1:0]          bpp;
    logic                        is_vga;

    assign is_vga = (color_mode_reg == MODE_VGA);

    always_comb
    begin
        if (is_vga)
        begin
            width  = WDIM_W'(VGA_WIDTH);
            height = HDIM_W'(VGA_HEIGHT);
            step   = STRIDE_W'(VGA_ROW_BYTES);
        end
        else
        begin
            if (frame_width_reg == '0)
                width = WDIM_W'(1);
            else if (32'(frame_width_reg) > MAX_WIDTH)
                width = WDIM_W'(MAX_WIDTH);
            else
                width = WDIM_W'(frame_width_reg);
            if (frame_height_reg == '0)
                height = HDIM_W'(1);
            else if (32'(frame_height_reg) > MAX_HEIGHT)
                height = HDIM_W'(MAX_HEIGHT);
            else
                height = HDIM_W'(frame_height_reg);
            step = row_stride_reg;
        end
    end

    assign end_col = (WDIM_W'(col_reg) + WDIM_W'(1)) >= width;
    assign end_row = (HDIM_W'(row_reg) + HDIM_W'(1)) >= height;

    // VGA gathering: first pixel of a group lands in bit 7
    assign pos_bit = 8'h80 >> fill_reg;

    always_comb
    begin
        for (int p = 0; p < PLANES; p++)
        begin
            gather_set[p] = gather_reg[p] | (pixel_index[p] ? pos_bit : 8'h00);
        end
    end

    assign vga_emit = (fill_reg == 3'd7) || end_col;

    // Grey g is g * 0x10 per color byte; out-of-range index gives black outside MODE_BYTE
    assign grey = (pixel_index < 8'd16) ? {pixel_index[3:0], 4'h0} : 8'h00;
    assign g5   = grey[7:3];
    assign g6   = grey[7:2];

    always_comb
    begin
        unique case (color_mode_reg)
            MODE_VGA:
            begin
                word = {gather_set[3], gather_set[2], gather_set[1], gather_set[0]};
                bpp  = 3'd1;
            end
            MODE_BYTE:
            begin
                word = {24'h0, pixel_index[3:0], 4'h0};
                bpp  = 3'd1;
            end
            MODE_RGB15:
            begin
                word = {17'h0, g5, g5, g5};
                bpp  = 3'd2;
            end
            MODE_RGB16:
            begin
                word = {16'h0, g5, g6, g5};
                bpp  = 3'd2;
            end
            MODE_RGB24, MODE_BGR24:
            begin
                word = {8'h0, grey, grey, grey};
                bpp  = 3'd3;
            end
            MODE_RGBX32, MODE_BGRX32:
            begin
                word = {8'h0, grey, grey, grey};
                bpp  = 3'd4;
            end
            default:
            begin
                word = '0;
                bpp  = 3'd1;
            end
        endcase
    end

    assign col_ext = ADDR_W'(col_reg);

    always_comb
    begin
        if (is_vga)
            col_offset = col_ext >> 3;
        else
        begin
            unique case (bpp)
                3'd2:    col_offset = col_ext << 1;
                3'd3:    col_offset = col_ext + (col_ext << 1);
                3'd4:    col_offset = col_ext << 2;
                default: col_offset = col_ext;
            endcase
        end
    end

    assign job.planar     = is_vga;
    assign job.word       = word;
    assign job.byte_count = bpp;
    assign job.addr       = base_reg + col_offset;
    assign job.frame_last = end_col && end_row;
    assign job_valid      = accept && (!is_vga || vga_emit);

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        base_next   = base_reg;
        gather_next = gather_reg;
        fill_next   = fill_reg;
        if (cfg_write_en)
        begin
            col_next    = '0;
            row_next    = '0;
            base_next   = '0;
            gather_next = '0;
            fill_next   = '0;
        end
        else if (accept)
        begin
            if (is_vga)
            begin
                if (vga_emit)
                begin
                    gather_next = '0;
                    fill_next   = '0;
                end
                else
                begin
                    gather_next = gather_set;
                    fill_next   = fill_reg + 3'd1;
                end
            end
            if (end_col)
            begin
                col_next  = '0;
                fill_next = '0;
                if (end_row)
                begin
                    row_next  = '0;
                    base_next = '0;
                end
                else
                begin
                    row_next  = row_reg + ROW_W'(1);
                    base_next = base_reg + ADDR_W'(step);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg   <= MODE_VGA;
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            row_stride_reg   <= ROW_STRIDE_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            base_reg         <= '0;
            gather_reg       <= '0;
            fill_reg         <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_COLOR_MODE:   color_mode_reg   <= color_mode_t'(cfg_data[MODE_W-1:0]);
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_REG_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_REG_W-1:0];
                    REG_ROW_STRIDE:   row_stride_reg   <= cfg_data[STRIDE_W-1:0];
                    default:          ;
                endcase
            end
            col_reg    <= col_next;
            row_reg    <= row_next;
            base_reg   <= base_next;
            gather_reg <= gather_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[src/pfc_queue.sv]
// Job queue between front end and back end.
module pfc_queue
    import pfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  pfc_job_t wr_job,
    input  logic     rd_en,
    output pfc_job_t rd_job,
    output logic     full,
    output logic     empty
);

    pfc_job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg, count_next;

    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/pfc_back.sv]
// Back end: expands jobs into framebuffer writes and holds the result register.
module pfc_back
    import pfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_avail,
    input  pfc_job_t           job,
    output logic               job_done,
    input  logic               pop,
    output logic               empty,
    output logic [WORD_W-1:0]  pixel_word,
    output logic [COUNT_W-1:0] byte_count,
    output logic [MASK_W-1:0]  plane_mask,
    output logic [ADDR_W-1:0]  byte_address,
    output logic               run_last,
    output logic               frame_last
);

    logic                 out_valid_reg, out_valid_next;
    logic [PLANE_W-1:0]   plane_reg, plane_next;
    logic [WORD_W-1:0]    word_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic                 run_last_reg;
    logic                 frame_last_reg;

    logic                 load;
    logic                 last_plane;
    logic                 job_last;
    logic [WORD_W-1:0]    word_sel;
    logic [COUNT_W-1:0]   count_sel;
    logic [MASK_W-1:0]    mask_sel;

    assign load       = (!out_valid_reg || pop) && job_avail;
    assign last_plane = (plane_reg == PLANE_W'(PLANES - 1));
    assign job_last   = !job.planar || last_plane;
    assign job_done   = load && job_last;

    always_comb
    begin
        if (job.planar)
        begin
            word_sel  = WORD_W'(job.word[8*plane_reg +: 8]);
            count_sel = 3'd1;
            mask_sel  = MASK_W'(1) << plane_reg;
        end
        else
        begin
            word_sel  = job.word;
            count_sel = job.byte_count;
            mask_sel  = '1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        plane_next     = plane_reg;
        if (!out_valid_reg || pop)
            out_valid_next = job_avail;
        if (load)
            plane_next = job_last ? '0 : plane_reg + PLANE_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            plane_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            plane_reg     <= plane_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg       <= word_sel;
            count_reg      <= count_sel;
            mask_reg       <= mask_sel;
            addr_reg       <= job.addr;
            run_last_reg   <= job_last;
            frame_last_reg <= job.frame_last;
        end
    end

    assign empty        = !out_valid_reg;
    assign pixel_word   = word_reg;
    assign byte_count   = count_reg;
    assign plane_mask   = mask_reg;
    assign byte_address = addr_reg;
    assign run_last     = run_last_reg;
    assign frame_last   = frame_last_reg;

endmodule

[src/pixel_format_converter.sv]
// Pixel format converter: grey-level pixel stream in, framebuffer write transactions out.
//
// Accepts one pixel per clock while full is low. The front end tracks column, row and
// row base and packs each pixel into a write job; in VGA planar mode it gathers eight
// pixels into four plane bytes and queues one job per group. A four-entry job queue
// separates it from the back end, which issues one write transaction per clock from its
// output register while pop is high and jobs are queued: one write per pixel in the
// packed modes, four one-byte plane writes per group of eight pixels in VGA mode. A
// pixel's first write passes the job queue and the output register before it is visible.
// Any configuration write restarts the frame; configure only while the block is drained.
module pixel_format_converter
    import pfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [INDEX_W-1:0]    pixel_index,
    output logic                  empty,
    input  logic                  pop,
    output logic [WORD_W-1:0]     pixel_word,
    output logic [COUNT_W-1:0]    byte_count,
    output logic [MASK_W-1:0]     plane_mask,
    output logic [ADDR_W-1:0]     byte_address,
    output logic                  run_last,
    output logic                  frame_last
);

    logic     accept;
    logic     job_valid;
    pfc_job_t front_job;
    pfc_job_t head_job;
    logic     queue_empty;
    logic     job_done;

    assign accept = push && !full;

    pfc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .pixel_index  (pixel_index),
        .job_valid    (job_valid),
        .job          (front_job)
    );

    pfc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_valid),
        .wr_job (front_job),
        .rd_en  (job_done),
        .rd_job (head_job),
        .full   (full),
        .empty  (queue_empty)
    );

    pfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_avail    (!queue_empty),
        .job          (head_job),
        .job_done     (job_done),
        .pop          (pop),
        .empty        (empty),
        .pixel_word   (pixel_word),
        .byte_count   (byte_count),
        .plane_mask   (plane_mask),
        .byte_address (byte_address),
        .run_last     (run_last),
        .frame_last   (frame_last)
    );

endmodule
